### hw/rtl/crt_pkg.sv
// Package for the concentric ring texture: widths, colors and the chain beat type.
`default_nettype none
package crt_pkg;
   localparam int MAX_SIDE   = 4096;
   localparam int SIDE_W     = 13;
   localparam int COORD_W    = 12;
   localparam int RING_W     = 8;
   localparam int SQ_W       = 25;   // side*side, dx*dx and dy*dy
   localparam int VAL_W      = 42;   // (dx^2+dy^2) * rings^2
   localparam int T_W        = 33;   // k * side^2
   localparam int Q_W        = 46;   // (k * side)^2 with headroom
   localparam int KBITS      = 9;    // ring index fits in 9 bits
   localparam int ADDR_W     = 3;

   localparam logic [ADDR_W-3:0] REG_SIDE  = 1'b0;
   localparam logic [ADDR_W-3:0] REG_RINGS = 1'b1;

   localparam logic [SIDE_W-1:0] RST_SIDE  = 13'd256;
   localparam logic [RING_W-1:0] RST_RINGS = 8'd5;

   localparam logic [7:0] EVEN_RED = 8'd200, EVEN_GREEN = 8'd150, EVEN_BLUE = 8'd50;
   localparam logic [7:0] ODD_RED  = 8'd50,  ODD_GREEN  = 8'd100, ODD_BLUE  = 8'd200;

   // One beat handed from cell to cell
   typedef struct packed {
      logic             valid;
      logic [VAL_W-1:0] v;
      logic [T_W-1:0]   t;
      logic [Q_W-1:0]   q;
      logic             odd;
   } crt_beat_type;
endpackage
`default_nettype wire

### hw/rtl/crt_front.sv
// Front pipeline: clamp, distance from center, squared radius scaled by ring count squared.
`default_nettype none
module crt_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire logic                        in_valid,
   input  wire logic [crt_pkg::COORD_W-1:0] pixel_x,
   input  wire logic [crt_pkg::COORD_W-1:0] pixel_y,
   input  wire logic [crt_pkg::SIDE_W-1:0]  side,
   input  wire logic [crt_pkg::RING_W-1:0]  rings,
   output crt_pkg::crt_beat_type            beat_out
);
   import crt_pkg::*;

   logic [SIDE_W-1:0] x_cl, y_cl;
   logic [SIDE_W:0]   x2, y2, sd;
   logic [SIDE_W-1:0] dx_in, dy_in, dx_ff, dy_ff;
   logic [SQ_W-1:0]   sx_ff, sy_ff;
   logic [SQ_W:0]     sum;
   logic [SQ_W+RING_W:0] p1_ff;
   logic [VAL_W-1:0]  p2_ff;
   logic [3:0]        vld_ff;

   // clamp and absolute offset from center, in doubled coordinates
   always_comb begin
      x_cl = ({1'b0, pixel_x} >= side) ? side - 13'd1 : {1'b0, pixel_x};
      y_cl = ({1'b0, pixel_y} >= side) ? side - 13'd1 : {1'b0, pixel_y};
      x2 = {x_cl, 1'b0};
      y2 = {y_cl, 1'b0};
      sd = {1'b0, side};
      dx_in = (x2 >= sd) ? SIDE_W'(x2 - sd) : SIDE_W'(sd - x2);
      dy_in = (y2 >= sd) ? SIDE_W'(y2 - sd) : SIDE_W'(sd - y2);
      sum = {1'b0, sx_ff} + {1'b0, sy_ff};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         sx_ff <= SQ_W'(dx_ff) * SQ_W'(dx_ff);
         sy_ff <= SQ_W'(dy_ff) * SQ_W'(dy_ff);
         p1_ff <= (SQ_W+RING_W+1)'(sum) * (SQ_W+RING_W+1)'(rings);
         p2_ff <= VAL_W'(p1_ff) * VAL_W'(rings);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   assign beat_out.valid = vld_ff[3];
   assign beat_out.v     = p2_ff;
   assign beat_out.t     = '0;
   assign beat_out.q     = '0;
   assign beat_out.odd   = 1'b0;
endmodule
`default_nettype wire

### hw/rtl/crt_cell.sv
// One cell of the ring index chain: decides one bit of floor(sqrt(v)/side).
`default_nettype none
module crt_cell #(
   parameter int BIT = 0
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire logic [crt_pkg::SQ_W-1:0]   side_sq,
   input  crt_pkg::crt_beat_type           beat_in,
   output crt_pkg::crt_beat_type           beat_out
);
   import crt_pkg::*;

   logic [Q_W-1:0] q_try;
   logic [T_W-1:0] t_try;
   logic           take;
   crt_beat_type   beat_in_c, beat_ff;

   // T = k*side^2, Q = (k*side)^2; setting bit b of k gives
   // Q + T<<(b+1) + side^2<<2b and T + side^2<<b
   always_comb begin
      q_try = beat_in.q + (Q_W'(beat_in.t) << (BIT + 1)) + (Q_W'(side_sq) << (2 * BIT));
      t_try = beat_in.t + (T_W'(side_sq) << BIT);
      take  = (q_try <= Q_W'(beat_in.v));
      beat_in_c       = beat_in;
      beat_in_c.t     = take ? t_try : beat_in.t;
      beat_in_c.q     = take ? q_try : beat_in.q;
      beat_in_c.odd   = take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (advance) begin
         beat_ff.valid <= beat_in_c.valid;
      end
      if (advance) begin
         beat_ff.v   <= beat_in_c.v;
         beat_ff.t   <= beat_in_c.t;
         beat_ff.q   <= beat_in_c.q;
         beat_ff.odd <= beat_in_c.odd;
      end
   end

   assign beat_out = beat_ff;
endmodule
`default_nettype wire

### hw/rtl/concentric_ring_texture_pixel.sv
// Top level of the concentric ring texture pixel generator.
// Takes one pixel per clock (req_pixel_x/y) and returns its ring color after passing
// four front stages (clamp/offset, two squares, two multiplies by the ring count) and a
// chain of nine cells that each settle one bit of the ring index, then an output register.
// Throughput is one pixel every clock while rsp_ready stays high; the whole pipe holds
// when the output register is full and not taken. Registers: 0x0 image_side (clamped to
// 2..4096 in use), 0x4 ring_count; write them only while the pipe is empty.
`default_nettype none
module concentric_ring_texture_pixel (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [crt_pkg::COORD_W-1:0] req_pixel_x,
   input  wire logic [crt_pkg::COORD_W-1:0] req_pixel_y,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [7:0]                       rsp_red,
   output logic [7:0]                       rsp_green,
   output logic [7:0]                       rsp_blue,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [crt_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [31:0]                 pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import crt_pkg::*;

   logic [SIDE_W-1:0] side_ff, side_eff;
   logic [RING_W-1:0] rings_ff;
   logic [SQ_W-1:0]   side_sq_ff;
   logic              advance, out_valid_ff, odd_ff;
   crt_beat_type      chain [KBITS+1];

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign pready    = 1'b1;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff  <= RST_SIDE;
         rings_ff <= RST_RINGS;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[ADDR_W-1:2])
            REG_SIDE:  side_ff  <= pwdata[SIDE_W-1:0];
            REG_RINGS: rings_ff <= pwdata[RING_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[ADDR_W-1:2])
         REG_SIDE:  prdata = {{(32-SIDE_W){1'b0}}, side_ff};
         REG_RINGS: prdata = {{(32-RING_W){1'b0}}, rings_ff};
         default:   prdata = '0;
      endcase
   end

   // effective side and its square
   always_comb begin
      priority if (side_ff < SIDE_W'(2))        side_eff = SIDE_W'(2);
      else if (side_ff > SIDE_W'(MAX_SIDE))     side_eff = SIDE_W'(MAX_SIDE);
      else                                      side_eff = side_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_sq_ff <= SQ_W'(65536);
      end else begin
         side_sq_ff <= SQ_W'(side_eff) * SQ_W'(side_eff);
      end
   end

   crt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .pixel_x  (req_pixel_x),
      .pixel_y  (req_pixel_y),
      .side     (side_eff),
      .rings    (rings_ff),
      .beat_out (chain[0])
   );

   // cells from the top ring bit down
   for (genvar g = 0; g < KBITS; g++) begin : g_cell
      crt_cell #(.BIT(KBITS - 1 - g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .side_sq  (side_sq_ff),
         .beat_in  (chain[g]),
         .beat_out (chain[g+1])
      );
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= chain[KBITS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         odd_ff <= chain[KBITS].odd;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_red   = odd_ff ? ODD_RED   : EVEN_RED;
   assign rsp_green = odd_ff ? ODD_GREEN : EVEN_GREEN;
   assign rsp_blue  = odd_ff ? ODD_BLUE  : EVEN_BLUE;
endmodule
`default_nettype wire

### hw/rtl/crt_checker.sv
// Port checker for the concentric ring texture, bound to the top level.
`default_nettype none
module crt_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_red,
   input wire logic [7:0] rsp_green,
   input wire logic [7:0] rsp_blue,
   input wire logic       pready
);
   import crt_pkg::*;

   // result beat stays valid with its red value unchanged until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red))
      else $error("result beat dropped or changed while stalled");

   // color is one of the two ring colors
   a_color: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_red == EVEN_RED && rsp_green == EVEN_GREEN && rsp_blue == EVEN_BLUE)
                 || (rsp_red == ODD_RED && rsp_green == ODD_GREEN && rsp_blue == ODD_BLUE))
      else $error("bad ring color");

   // input side open whenever output is free to move
   a_ready: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled without output back-pressure");

   // no result right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   a_pready: assert property (@(posedge clock) pready)
      else $error("pready low");
endmodule

bind concentric_ring_texture_pixel crt_checker u_crt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_red   (rsp_red),
   .rsp_green (rsp_green),
   .rsp_blue  (rsp_blue),
   .pready    (pready)
);
`default_nettype wire

### test/tb_concentric_ring_texture_pixel.sv
// Testbench for the concentric ring texture pixel generator: random pixels checked against a ring predictor.
`default_nettype none
module tb_concentric_ring_texture_pixel;
   timeunit 1ns;
   timeprecision 1ps;
   import crt_pkg::*;

   typedef struct {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } pixel_type;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;

   localparam int LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [COORD_W-1:0] req_pixel_x = '0;
   logic [COORD_W-1:0] req_pixel_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_red, rsp_green, rsp_blue;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   concentric_ring_texture_pixel dut (.*);

   // shadow copies of the texture registers
   logic [SIDE_W-1:0] side_reg = RST_SIDE;
   logic [RING_W-1:0] rings_reg = RST_RINGS;

   pixel_type pending_pixels[$];
   color_type expected_colors[$];
   int failures = 0;
   int cycle = 0;
   bit calm = 0;      // no idling on either side
   int hold_off = 0;  // cycles the receiver still holds off

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] root, rem, bitv;
      root = 0;
      rem = v;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // ring color of one pixel under the current register values
   function automatic color_type ring_color(pixel_type p);
      logic [63:0] side, x, y, dx, dy, ring;
      color_type c;
      side = 64'(side_reg);
      if (side < 2) side = 2;
      if (side > MAX_SIDE) side = MAX_SIDE;
      x = 64'(p.x);
      y = 64'(p.y);
      if (x >= side) x = side - 1;
      if (y >= side) y = side - 1;
      dx = (2 * x >= side) ? 2 * x - side : side - 2 * x;
      dy = (2 * y >= side) ? 2 * y - side : side - 2 * y;
      ring = isqrt((dx * dx + dy * dy) * 64'(rings_reg) * 64'(rings_reg)) / side;
      if (ring[0]) c = '{ODD_RED, ODD_GREEN, ODD_BLUE};
      else c = '{EVEN_RED, EVEN_GREEN, EVEN_BLUE};
      return c;
   endfunction

   // driver: one pixel beat at a time from the pending queue
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_colors.push_back(ring_color(pending_pixels.pop_front()));
         end
         if ((!req_valid || req_ready) && pending_pixels.size() > 0 &&
             (calm || $urandom_range(99) >= 30)) begin
            req_valid <= 1'b1;
            req_pixel_x <= pending_pixels[0].x;
            req_pixel_y <= pending_pixels[0].y;
         end else if (req_valid && req_ready) begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver with random stalls and one long hold-off
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || $urandom_range(99) >= 30;
      end
   end

   // monitor: compare each color beat with the oldest expectation
   always @(posedge clock) begin
      color_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_colors.size() == 0) begin
            $error("unexpected color beat");
            failures++;
         end else begin
            e = expected_colors.pop_front();
            if (rsp_red !== e.red) begin
               $error("red: expected %0d, got %0d", e.red, rsp_red);
               failures++;
            end
            if (rsp_green !== e.green) begin
               $error("green: expected %0d, got %0d", e.green, rsp_green);
               failures++;
            end
            if (rsp_blue !== e.blue) begin
               $error("blue: expected %0d, got %0d", e.blue, rsp_blue);
               failures++;
            end
         end
      end
   end

   task automatic csr_write(logic [ADDR_W-3:0] idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      // predictor follows the register truncation
      if (idx == REG_SIDE) side_reg = value[SIDE_W-1:0];
      else rings_reg = value[RING_W-1:0];
   endtask

   task automatic wait_drained();
      while (pending_pixels.size() > 0 || req_valid || expected_colors.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic add_pixel(int x, int y);
      pixel_type p;
      p.x = COORD_W'(x);
      p.y = COORD_W'(y);
      pending_pixels.push_back(p);
   endtask

   // pixels mostly inside the image for the current side, with some beyond it
   task automatic random_phase(int count);
      int s;
      s = (side_reg < 2) ? 2 : (side_reg > MAX_SIDE ? MAX_SIDE : int'(side_reg));
      repeat (count) begin
         if ($urandom_range(9) < 8)
            add_pixel($urandom_range(s - 1), $urandom_range(s - 1));
         else
            add_pixel($urandom_range(4095), $urandom_range(4095));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset values, corners, center, out-of-range coordinates
      add_pixel(0, 0);
      add_pixel(128, 128);
      add_pixel(255, 0);
      add_pixel(4095, 4095);
      add_pixel(4095, 0);
      add_pixel(0, 4095);
      add_pixel(2730, 1365);
      add_pixel(100, 140);
      wait_drained();

      // side too small, zero rings, side above maximum, widest fields
      csr_write(REG_SIDE, 0);
      csr_write(REG_RINGS, 0);
      add_pixel(0, 0);
      add_pixel(1, 1);
      add_pixel(4095, 4095);
      wait_drained();
      csr_write(REG_SIDE, 32'hFFFF_FFFF);
      csr_write(REG_RINGS, 255);
      add_pixel(0, 0);
      add_pixel(2048, 2048);
      add_pixel(4095, 4095);
      add_pixel(1, 4094);
      add_pixel(2047, 3071);
      wait_drained();
      csr_write(REG_SIDE, 4096);
      csr_write(REG_RINGS, 1);
      add_pixel(0, 2048);
      add_pixel(2048, 0);
      wait_drained();

      // random phases over several settings
      csr_write(REG_SIDE, 2);
      csr_write(REG_RINGS, 255);
      random_phase(40);
      wait_drained();
      csr_write(REG_SIDE, 64);
      csr_write(REG_RINGS, 7);
      hold_off = 200;  // long receiver stall while the sender keeps offering
      random_phase(100);
      wait_drained();
      csr_write(REG_SIDE, $urandom_range(2, 300));
      csr_write(REG_RINGS, $urandom_range(1, 255));
      calm = 1;
      random_phase(100);
      wait_drained();
      calm = 0;
      csr_write(REG_SIDE, $urandom_range(8191));
      csr_write(REG_RINGS, $urandom_range(255));
      random_phase(100);
      wait_drained();
      csr_write(REG_SIDE, 4096);
      csr_write(REG_RINGS, $urandom_range(1, 255));
      random_phase(60);
      wait_drained();
      csr_write(REG_SIDE, 255);
      csr_write(REG_RINGS, 0);
      random_phase(40);
      wait_drained();
      csr_write(REG_SIDE, $urandom_range(2, 1000));
      csr_write(REG_RINGS, $urandom_range(1, 40));
      random_phase(100);
      wait_drained();

      if (failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
`default_nettype wire

### sim.f
hw/rtl/crt_pkg.sv
hw/rtl/crt_front.sv
hw/rtl/crt_cell.sv
hw/rtl/concentric_ring_texture_pixel.sv
hw/rtl/crt_checker.sv
test/tb_concentric_ring_texture_pixel.sv
